### rtl/bgd_pkg.sv
// Shared types, constants and error codes of the BMP 24-bit to gray decoder.
// No dependencies; used by the channel interfaces and the top level.
package bgd_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COORD_W = 14;
   localparam int ERR_W   = 4;
   localparam int LEN_W   = 31;
   localparam int SUM_W   = 18;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ERR_W-1:0]   err_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [SUM_W-1:0]   sum_type;

   // header layout and checks
   localparam int          HDR_LEN       = 54;
   localparam int          MAX_DIMENSION = 10000;
   localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
   localparam logic [31:0] INFO_SIZE     = 32'd40;
   localparam logic [15:0] BIT_COUNT     = 16'd24;

   // gray weights (per mille) and reciprocal of 1000 for the divide
   localparam int W_RED     = 299;
   localparam int W_GREEN   = 587;
   localparam int W_BLUE    = 114;
   localparam int RECIP_SH  = 28;
   localparam int RECIP_MUL = 268436;   // ceil(2^28 / 1000), exact for sums up to 255000
   localparam int PROD_W    = SUM_W + 19;

   // completion codes
   localparam err_type ERR_OK          = 4'd0;
   localparam err_type ERR_SHORT       = 4'd1;
   localparam err_type ERR_SIGNATURE   = 4'd2;
   localparam err_type ERR_SIZE        = 4'd3;
   localparam err_type ERR_INFOSIZE    = 4'd4;
   localparam err_type ERR_DIMS        = 4'd5;
   localparam err_type ERR_BITCOUNT    = 4'd6;
   localparam err_type ERR_COMPRESSION = 4'd7;
   localparam err_type ERR_OFFSET      = 4'd8;
   localparam err_type ERR_TRUNCATED   = 4'd9;
   localparam err_type ERR_TRAILING    = 4'd10;

endpackage

### rtl/bgd_byte_if.sv
// Byte channel carrying the BMP file stream, valid/ready handshake.
// Depends on bgd_pkg for the byte type.
interface bgd_byte_if;
   logic               valid;
   logic               ready;
   bgd_pkg::byte_type  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/bgd_pix_if.sv
// Result channel carrying gray pixels and the end-of-file status.
// Depends on bgd_pkg for field types.
interface bgd_pix_if;
   logic               valid;
   logic               ready;
   logic               pixel_valid;
   bgd_pkg::coord_type pixel_x;
   bgd_pkg::coord_type pixel_y;
   bgd_pkg::byte_type  gray_level;
   logic               finished;
   bgd_pkg::err_type   error_code;

   modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
                   output gray_level, output finished, output error_code, input ready);
   modport sink   (input valid, input pixel_valid, input pixel_x, input pixel_y,
                   input gray_level, input finished, input error_code, output ready);
endinterface

### rtl/bmp24_to_gray_decoder_top.sv
// BMP 24-bit to gray decoder: one file byte per transfer in, zero or one result out.
// A result reaches rsp_bus through the input register, the parse stage and the
// divide/output register. Throughput: one byte per cycle while not stalled, set by the
// single parse stage whose state feeds back each cycle. Stalls back up stage by stage.
// Reset (synchronous): header mode, all counters cleared; header bytes undefined
// until the next file's header arrives. Depends on bgd_pkg, bgd_byte_if, bgd_pix_if.
module bmp24_to_gray_decoder_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  bgd_pkg::len_type     csr_wr_data,
   bgd_byte_if.sink             req_bus,
   bgd_pix_if.source            rsp_bus
);

   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_PIXEL  = 2'd1;
   localparam logic [1:0] MODE_PAD    = 2'd2;
   localparam logic [1:0] MODE_SKIP   = 2'd3;

   localparam logic [1:0] PH_BLUE  = 2'd0;
   localparam logic [1:0] PH_GREEN = 2'd1;
   localparam logic [1:0] PH_RED   = 2'd2;

   localparam int HDR_TOP    = bgd_pkg::HDR_LEN - 2;   // last stored header byte position
   localparam int HC_W       = $clog2(bgd_pkg::HDR_LEN);
   localparam int COORD_W_P1 = bgd_pkg::COORD_W + 1;

   // configuration
   bgd_pkg::len_type  file_len_ff;

   // stage 1: input register
   logic              s1_v_ff;
   bgd_pkg::byte_type s1_byte_ff;

   // parse state
   logic [1:0]         mode_ff, mode_in;
   logic [HC_W-1:0]    hc_ff, hc_in;
   bgd_pkg::len_type   bl_ff, bl_in;
   bgd_pkg::coord_type col_ff, col_in;
   bgd_pkg::coord_type row_ff, row_in;
   logic [1:0]         ph_ff, ph_in;
   bgd_pkg::byte_type  blue_ff, blue_in;
   bgd_pkg::byte_type  green_ff, green_in;
   logic [1:0]         pad_ff, pad_in;
   bgd_pkg::byte_type  hdr_ff [HDR_TOP+1];
   logic               hdr_shift;

   // stage 2: parse result
   logic               s2_v_ff;
   logic               s2_pix_ff;
   bgd_pkg::coord_type s2_x_ff;
   bgd_pkg::coord_type s2_y_ff;
   bgd_pkg::sum_type   s2_sum_ff;
   logic               s2_fin_ff;
   bgd_pkg::err_type   s2_err_ff;

   // stage 3: output register
   logic               rsp_v_ff;
   logic               rsp_pix_ff;
   bgd_pkg::coord_type rsp_x_ff;
   bgd_pkg::coord_type rsp_y_ff;
   bgd_pkg::byte_type  rsp_gray_ff;
   logic               rsp_fin_ff;
   bgd_pkg::err_type   rsp_err_ff;

   // handshake chain
   logic s3_rdy, s2_rdy, s1_rdy, proc_fire;

   // parse outputs
   logic               res_pix, res_fin;
   bgd_pkg::err_type   res_err;
   bgd_pkg::coord_type res_x, res_y;
   bgd_pkg::sum_type   res_sum;
   logic               go_next, go_rowdone;
   bgd_pkg::len_type   bl_dec;
   logic [COORD_W_P1-1:0] col_inc, row_inc;

   // header fields
   logic [15:0]        hdr_sig, hdr_bits;
   logic [31:0]        hdr_size, hdr_offset, hdr_info, hdr_width, hdr_height, hdr_comp;
   logic [31:0]        size_expect;
   bgd_pkg::coord_type img_w, img_h;
   bgd_pkg::err_type   chk_err;
   logic [bgd_pkg::PROD_W-1:0] gray_prod;

   // advance conditions
   assign s3_rdy    = !rsp_v_ff || rsp_bus.ready;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign proc_fire = s1_v_ff && s2_rdy;
   assign req_bus.ready = s1_rdy;

   // header field extraction: file byte j sits at hdr_ff[HDR_TOP-j]
   assign hdr_sig    = {hdr_ff[HDR_TOP-1], hdr_ff[HDR_TOP-0]};
   assign hdr_size   = {hdr_ff[HDR_TOP-5], hdr_ff[HDR_TOP-4],
                        hdr_ff[HDR_TOP-3], hdr_ff[HDR_TOP-2]};
   assign hdr_offset = {hdr_ff[HDR_TOP-13], hdr_ff[HDR_TOP-12],
                        hdr_ff[HDR_TOP-11], hdr_ff[HDR_TOP-10]};
   assign hdr_info   = {hdr_ff[HDR_TOP-17], hdr_ff[HDR_TOP-16],
                        hdr_ff[HDR_TOP-15], hdr_ff[HDR_TOP-14]};
   assign hdr_width  = {hdr_ff[HDR_TOP-21], hdr_ff[HDR_TOP-20],
                        hdr_ff[HDR_TOP-19], hdr_ff[HDR_TOP-18]};
   assign hdr_height = {hdr_ff[HDR_TOP-25], hdr_ff[HDR_TOP-24],
                        hdr_ff[HDR_TOP-23], hdr_ff[HDR_TOP-22]};
   assign hdr_bits   = {hdr_ff[HDR_TOP-29], hdr_ff[HDR_TOP-28]};
   assign hdr_comp   = {hdr_ff[HDR_TOP-33], hdr_ff[HDR_TOP-32],
                        hdr_ff[HDR_TOP-31], hdr_ff[HDR_TOP-30]};
   assign img_w      = hdr_width[bgd_pkg::COORD_W-1:0];
   assign img_h      = hdr_height[bgd_pkg::COORD_W-1:0];

   // remaining count after this byte (saturates at zero)
   assign bl_dec      = (bl_ff != '0) ? bl_ff - 1'b1 : '0;
   assign size_expect = {1'b0, bl_dec} + 32'(bgd_pkg::HDR_LEN);

   // header checks in priority order
   always_comb begin
      priority if (hdr_sig != bgd_pkg::BMP_SIGNATURE) begin
         chk_err = bgd_pkg::ERR_SIGNATURE;
      end else if (hdr_size != size_expect) begin
         chk_err = bgd_pkg::ERR_SIZE;
      end else if (hdr_info != bgd_pkg::INFO_SIZE) begin
         chk_err = bgd_pkg::ERR_INFOSIZE;
      end else if (hdr_width > 32'(bgd_pkg::MAX_DIMENSION) ||
                   hdr_height > 32'(bgd_pkg::MAX_DIMENSION)) begin
         chk_err = bgd_pkg::ERR_DIMS;
      end else if (hdr_bits != bgd_pkg::BIT_COUNT) begin
         chk_err = bgd_pkg::ERR_BITCOUNT;
      end else if (hdr_comp != '0) begin
         chk_err = bgd_pkg::ERR_COMPRESSION;
      end else if (hdr_offset != 32'(bgd_pkg::HDR_LEN)) begin
         chk_err = bgd_pkg::ERR_OFFSET;
      end else begin
         chk_err = bgd_pkg::ERR_OK;
      end
   end

   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;

   // parse one byte: next state and the result it causes
   always_comb begin
      mode_in   = mode_ff;
      hc_in     = hc_ff;
      bl_in     = bl_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ph_in     = ph_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      pad_in    = pad_ff;
      hdr_shift = 1'b0;
      res_pix   = 1'b0;
      res_fin   = 1'b0;
      res_err   = bgd_pkg::ERR_OK;
      res_x     = '0;
      res_y     = '0;
      res_sum   = '0;
      go_next   = 1'b0;
      go_rowdone = 1'b0;

      unique case (mode_ff)
         MODE_HEADER: begin
            if (hc_ff == '0) begin
               bl_in = (file_len_ff != '0) ? file_len_ff - 1'b1 : '0;
            end else begin
               bl_in = bl_dec;
            end
            if (hc_ff == '0 && file_len_ff < bgd_pkg::LEN_W'(bgd_pkg::HDR_LEN)) begin
               res_fin = 1'b1;
               res_err = bgd_pkg::ERR_SHORT;
            end else if (hc_ff == HC_W'(bgd_pkg::HDR_LEN - 1)) begin
               // last header byte: run the checks
               hc_in = '0;
               if (chk_err != bgd_pkg::ERR_OK) begin
                  res_fin = 1'b1;
                  res_err = chk_err;
               end else begin
                  col_in = '0;
                  row_in = '0;
                  if (img_w == '0 || img_h == '0) begin
                     res_fin = 1'b1;
                     res_err = (bl_dec != '0) ? bgd_pkg::ERR_TRAILING : bgd_pkg::ERR_OK;
                  end else begin
                     go_next = 1'b1;
                  end
               end
            end else begin
               hdr_shift = 1'b1;
               hc_in     = hc_ff + 1'b1;
            end
         end
         MODE_PIXEL: begin
            bl_in = bl_dec;
            unique case (ph_ff)
               PH_BLUE: begin
                  blue_in = s1_byte_ff;
                  ph_in   = PH_GREEN;
               end
               PH_GREEN: begin
                  green_in = s1_byte_ff;
                  ph_in    = PH_RED;
               end
               default: begin
                  res_pix = 1'b1;
                  res_x   = col_ff;
                  res_y   = img_h - 1'b1 - row_ff;
                  res_sum = bgd_pkg::SUM_W'(bgd_pkg::W_RED)   * bgd_pkg::SUM_W'(s1_byte_ff)
                          + bgd_pkg::SUM_W'(bgd_pkg::W_GREEN) * bgd_pkg::SUM_W'(green_ff)
                          + bgd_pkg::SUM_W'(bgd_pkg::W_BLUE)  * bgd_pkg::SUM_W'(blue_ff);
                  ph_in   = PH_BLUE;
                  if (col_inc >= {1'b0, img_w}) begin
                     // row of pixels complete: padding or row end
                     col_in = col_inc[bgd_pkg::COORD_W-1:0];
                     if (img_w[1:0] == 2'd0) begin
                        go_rowdone = 1'b1;
                     end else if (bl_dec < bgd_pkg::LEN_W'(img_w[1:0])) begin
                        res_fin = 1'b1;
                        res_err = bgd_pkg::ERR_TRUNCATED;
                     end else begin
                        pad_in  = img_w[1:0];
                        mode_in = MODE_PAD;
                     end
                  end else begin
                     col_in  = col_inc[bgd_pkg::COORD_W-1:0];
                     go_next = 1'b1;
                  end
               end
            endcase
         end
         MODE_PAD: begin
            bl_in  = bl_dec;
            pad_in = (pad_ff != '0) ? pad_ff - 1'b1 : '0;
            if (pad_in == '0) begin
               go_rowdone = 1'b1;
            end
         end
         MODE_SKIP: begin
            bl_in = bl_dec;
            if (bl_dec == '0) begin
               mode_in = MODE_HEADER;
            end
         end
      endcase

      // row end: last row finishes the image, else on to the next pixel
      if (go_rowdone) begin
         col_in = '0;
         row_in = row_inc[bgd_pkg::COORD_W-1:0];
         if (row_inc >= {1'b0, img_h}) begin
            res_fin = 1'b1;
            res_err = (bl_in != '0) ? bgd_pkg::ERR_TRAILING : bgd_pkg::ERR_OK;
         end else begin
            go_next = 1'b1;
         end
      end

      // next pixel needs three bytes left
      if (go_next) begin
         if (bl_in < bgd_pkg::LEN_W'(3)) begin
            res_fin = 1'b1;
            res_err = bgd_pkg::ERR_TRUNCATED;
         end else begin
            mode_in = MODE_PIXEL;
            ph_in   = PH_BLUE;
         end
      end

      // end of file: swallow what remains, then wait for the next header
      if (res_fin) begin
         mode_in = (bl_in != '0) ? MODE_SKIP : MODE_HEADER;
         col_in  = '0;
         row_in  = '0;
         ph_in   = PH_BLUE;
         pad_in  = '0;
         hc_in   = '0;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         file_len_ff <= '0;
      end else if (csr_wr_en) begin
         file_len_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_bus.valid) begin
         s1_byte_ff <= req_bus.data_byte;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HEADER;
         hc_ff    <= '0;
         bl_ff    <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         ph_ff    <= PH_BLUE;
         blue_ff  <= '0;
         green_ff <= '0;
         pad_ff   <= '0;
      end else if (proc_fire) begin
         mode_ff  <= mode_in;
         hc_ff    <= hc_in;
         bl_ff    <= bl_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ph_ff    <= ph_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
         pad_ff   <= pad_in;
      end
   end

   // header shift line, newest byte at position 0
   always_ff @(posedge clock) begin
      if (proc_fire && hdr_shift) begin
         hdr_ff[0] <= s1_byte_ff;
         for (int k = 1; k <= HDR_TOP; k++) begin
            hdr_ff[k] <= hdr_ff[k-1];
         end
      end
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= proc_fire && (res_pix || res_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_pix_ff <= res_pix;
         s2_x_ff   <= res_x;
         s2_y_ff   <= res_y;
         s2_sum_ff <= res_sum;
         s2_fin_ff <= res_fin;
         s2_err_ff <= res_err;
      end
   end

   // divide by 1000 through the reciprocal
   assign gray_prod = bgd_pkg::PROD_W'(s2_sum_ff) * bgd_pkg::PROD_W'(bgd_pkg::RECIP_MUL);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         rsp_pix_ff  <= s2_pix_ff;
         rsp_x_ff    <= s2_x_ff;
         rsp_y_ff    <= s2_y_ff;
         rsp_gray_ff <= gray_prod[bgd_pkg::RECIP_SH +: bgd_pkg::BYTE_W];
         rsp_fin_ff  <= s2_fin_ff;
         rsp_err_ff  <= s2_err_ff;
      end
   end

   assign rsp_bus.valid       = rsp_v_ff;
   assign rsp_bus.pixel_valid = rsp_pix_ff;
   assign rsp_bus.pixel_x     = rsp_x_ff;
   assign rsp_bus.pixel_y     = rsp_y_ff;
   assign rsp_bus.gray_level  = rsp_gray_ff;
   assign rsp_bus.finished    = rsp_fin_ff;
   assign rsp_bus.error_code  = rsp_err_ff;

endmodule

### test/bgd_gray_scoreboard.sv
// Scoreboard for the BMP 24-bit to gray decoder: watches the byte channel, the result
// channel and the length register, predicts each result and compares it field by field.
// Depends on bgd_pkg, bgd_byte_if and bgd_pix_if.
module bgd_gray_scoreboard (
   input  logic              clock,
   input  logic              reset,
   bgd_byte_if               req_mon,
   bgd_pix_if                rsp_mon,
   input  logic              csr_wr_en,
   input  bgd_pkg::len_type  csr_wr_data,
   output int                n_fail,
   output int                n_pending,
   output int                n_pixels,
   output int                n_ends,
   output bit [15:0]         codes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [1:0] MODE_HEADER = 2'd0;
   localparam bit [1:0] MODE_PIXEL  = 2'd1;
   localparam bit [1:0] MODE_PAD    = 2'd2;
   localparam bit [1:0] MODE_SKIP   = 2'd3;

   typedef struct packed {
      logic               pix;
      bgd_pkg::coord_type x;
      bgd_pkg::coord_type y;
      bgd_pkg::byte_type  gray;
      logic               fin;
      bgd_pkg::err_type   err;
   } pix_rec_type;

   // decoder mirror
   bgd_pkg::byte_type hdr_mem [bgd_pkg::HDR_LEN];
   bit [31:0]   left_cnt;
   bit [31:0]   col_cnt;
   bit [31:0]   row_cnt;
   bit [31:0]   hdr_cnt;
   bit [31:0]   len_reg;
   bit [1:0]    phase;
   bit [7:0]    blue_q;
   bit [7:0]    green_q;
   bit [1:0]    pad_cnt;
   bit [1:0]    mode;
   pix_rec_type out_rec;
   pix_rec_type expected_pix_q [$];

   task automatic report_fail(string msg);
      n_fail++;
      if (n_fail <= 30) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_fail($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic bit [31:0] le16(int o);
      return {16'h0, hdr_mem[o+1], hdr_mem[o]};
   endfunction

   function automatic bit [31:0] le32(int o);
      return {hdr_mem[o+3], hdr_mem[o+2], hdr_mem[o+1], hdr_mem[o]};
   endfunction

   function automatic bit [31:0] img_w();
      return le32(18) & 32'h3FFF;
   endfunction

   function automatic bit [31:0] img_h();
      return le32(22) & 32'h3FFF;
   endfunction

   // close the file with a status; leftover bytes get swallowed
   function automatic void end_file(bgd_pkg::err_type code);
      out_rec.fin = 1'b1;
      out_rec.err = code;
      mode    = (left_cnt != 0) ? MODE_SKIP : MODE_HEADER;
      col_cnt = 0;
      row_cnt = 0;
      phase   = 0;
      pad_cnt = 0;
      hdr_cnt = 0;
   endfunction

   // header checks in their fixed priority
   function automatic bgd_pkg::err_type header_fault();
      if (le16(0) != {16'h0, bgd_pkg::BMP_SIGNATURE}) return bgd_pkg::ERR_SIGNATURE;
      if (le32(2) != left_cnt + bgd_pkg::HDR_LEN) return bgd_pkg::ERR_SIZE;
      if (le32(14) != bgd_pkg::INFO_SIZE) return bgd_pkg::ERR_INFOSIZE;
      if (le32(18) > 32'(bgd_pkg::MAX_DIMENSION) || le32(22) > 32'(bgd_pkg::MAX_DIMENSION))
         return bgd_pkg::ERR_DIMS;
      if (le16(28) != {16'h0, bgd_pkg::BIT_COUNT}) return bgd_pkg::ERR_BITCOUNT;
      if (le32(30) != 0) return bgd_pkg::ERR_COMPRESSION;
      if (le32(10) != bgd_pkg::HDR_LEN) return bgd_pkg::ERR_OFFSET;
      return bgd_pkg::ERR_OK;
   endfunction

   function automatic void start_pixel();
      if (left_cnt < 3) begin
         end_file(bgd_pkg::ERR_TRUNCATED);
      end else begin
         mode  = MODE_PIXEL;
         phase = 0;
      end
   endfunction

   function automatic void finish_row();
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= img_h()) begin
         end_file((left_cnt != 0) ? bgd_pkg::ERR_TRAILING : bgd_pkg::ERR_OK);
      end else begin
         start_pixel();
      end
   endfunction

   // advance the mirror by one file byte; out_rec holds the result, if any
   function automatic void decode_byte(bgd_pkg::byte_type b);
      bgd_pkg::err_type fault;
      bit [31:0] sum;
      bit [31:0] ypos;
      bit [31:0] pad;
      out_rec = '0;
      case (mode)
         MODE_HEADER: begin
            if (hdr_cnt >= bgd_pkg::HDR_LEN) hdr_cnt = 0;
            if (hdr_cnt == 0) begin
               left_cnt = (len_reg != 0) ? len_reg - 1 : 0;
               if (len_reg < bgd_pkg::HDR_LEN) begin
                  end_file(bgd_pkg::ERR_SHORT);
                  return;
               end
            end else if (left_cnt != 0) begin
               left_cnt--;
            end
            hdr_mem[hdr_cnt] = b;
            hdr_cnt++;
            if (hdr_cnt == bgd_pkg::HDR_LEN) begin
               fault   = header_fault();
               hdr_cnt = 0;
               if (fault != bgd_pkg::ERR_OK) begin
                  end_file(fault);
               end else begin
                  col_cnt = 0;
                  row_cnt = 0;
                  if (img_w() == 0 || img_h() == 0) begin
                     end_file((left_cnt != 0) ? bgd_pkg::ERR_TRAILING : bgd_pkg::ERR_OK);
                  end else begin
                     start_pixel();
                  end
               end
            end
         end
         MODE_PIXEL: begin
            if (left_cnt != 0) left_cnt--;
            if (phase == 0) begin
               blue_q = b;
               phase  = 1;
            end else if (phase == 1) begin
               green_q = b;
               phase   = 2;
            end else begin
               sum  = bgd_pkg::W_RED * b + bgd_pkg::W_GREEN * green_q
                    + bgd_pkg::W_BLUE * blue_q;
               ypos = img_h() - 1 - row_cnt;
               out_rec.pix  = 1'b1;
               out_rec.gray = 8'(sum / 1000);
               out_rec.x    = col_cnt[13:0];
               out_rec.y    = ypos[13:0];
               phase = 0;
               col_cnt++;
               if (col_cnt >= img_w()) begin
                  // row padding is width mod 4 bytes
                  pad = img_w() & 3;
                  if (pad == 0) begin
                     finish_row();
                  end else if (left_cnt < pad) begin
                     end_file(bgd_pkg::ERR_TRUNCATED);
                  end else begin
                     pad_cnt = pad[1:0];
                     mode    = MODE_PAD;
                  end
               end else begin
                  start_pixel();
               end
            end
         end
         MODE_PAD: begin
            if (left_cnt != 0) left_cnt--;
            if (pad_cnt != 0) pad_cnt--;
            if (pad_cnt == 0) finish_row();
         end
         default: begin
            if (left_cnt != 0) left_cnt--;
            if (left_cnt == 0) mode = MODE_HEADER;
         end
      endcase
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin
      pix_rec_type want;
      if (reset) begin
         foreach (hdr_mem[k]) hdr_mem[k] = '0;
         left_cnt = 0;
         col_cnt  = 0;
         row_cnt  = 0;
         hdr_cnt  = 0;
         len_reg  = 0;
         phase    = 0;
         blue_q   = 0;
         green_q  = 0;
         pad_cnt  = 0;
         mode     = MODE_HEADER;
         expected_pix_q.delete();
      end else begin
         if (csr_wr_en) len_reg = {1'b0, csr_wr_data};
         // compare a result transfer against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pix_q.size() == 0) begin
               report_fail($sformatf("result with nothing pending (x %0d y %0d fin %0d)",
                                     rsp_mon.pixel_x, rsp_mon.pixel_y, rsp_mon.finished));
            end else begin
               want = expected_pix_q.pop_front();
               check_field("pixel_valid", rsp_mon.pixel_valid, want.pix);
               check_field("pixel_x", rsp_mon.pixel_x, want.x);
               check_field("pixel_y", rsp_mon.pixel_y, want.y);
               check_field("gray_level", rsp_mon.gray_level, want.gray);
               check_field("finished", rsp_mon.finished, want.fin);
               check_field("error_code", rsp_mon.error_code, want.err);
               if (want.pix) n_pixels++;
               if (want.fin) begin
                  n_ends++;
                  codes_seen[want.err] = 1'b1;
               end
            end
         end
         // predict for a byte transfer
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.data_byte);
            if (out_rec.pix || out_rec.fin) expected_pix_q.push_back(out_rec);
         end
      end
      n_pending = expected_pix_q.size();
   end

   initial begin
      n_fail     = 0;
      n_pending  = 0;
      n_pixels   = 0;
      n_ends     = 0;
      codes_seen = '0;
   end

endmodule

### test/tb_top.sv
// Testbench top for the BMP 24-bit to gray decoder: builds BMP files, streams them with
// random idling and back-pressure, and gives the verdict from the scoreboard's counts.
// Depends on bgd_pkg, bgd_byte_if, bgd_pix_if, bgd_gray_scoreboard and the decoder top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_BYTES = 70;

   typedef struct {
      bit [15:0] sig;
      bit [31:0] size;
      bit [31:0] offset;
      bit [31:0] info;
      bit [31:0] wid;
      bit [31:0] hgt;
      bit [15:0] bpp;
      bit [31:0] comp;
   } bmp_head_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   bgd_pkg::len_type  csr_wr_data;
   int                n_fail;
   int                n_pending;
   int                n_pixels;
   int                n_ends;
   bit [15:0]         codes_seen;
   int                idle_pct;
   int                stall_pct;
   bit                rsp_hold;
   int                n_cycles;
   int                n_files;
   int                n_bytes;
   bgd_pkg::byte_type file_q [$];

   bgd_byte_if req_if ();
   bgd_pix_if  rsp_if ();

   bmp24_to_gray_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if)
   );

   bgd_gray_scoreboard i_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .n_fail      (n_fail),
      .n_pending   (n_pending),
      .n_pixels    (n_pixels),
      .n_ends      (n_ends),
      .codes_seen  (codes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", n_cycles, n_pending);
         $display("tb_top failed");
         $finish;
      end
   end

   // result side: random stalls, plus a forced hold-off when requested
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic bmp_head_type clean_head(bit [31:0] len, bit [31:0] w, bit [31:0] h);
      bmp_head_type hd;
      hd.sig    = bgd_pkg::BMP_SIGNATURE;
      hd.size   = len;
      hd.offset = bgd_pkg::HDR_LEN;
      hd.info   = bgd_pkg::INFO_SIZE;
      hd.wid    = w;
      hd.hgt    = h;
      hd.bpp    = bgd_pkg::BIT_COUNT;
      hd.comp   = 0;
      return hd;
   endfunction

   function automatic bit [31:0] pixel_bytes(bit [31:0] w, bit [31:0] h);
      if (w == 0 || h == 0) return 0;
      return h * (3 * w + (w & 3));
   endfunction

   function automatic void put_le(int o, bit [31:0] v, int nb);
      for (int k = 0; k < nb; k++) file_q[o+k] = v[8*k +: 8];
   endfunction

   // random bytes for the whole file, then the header fields on top
   function automatic void build_file(bit [31:0] len, bmp_head_type hd);
      int unsigned n;
      file_q.delete();
      n = (len == 0) ? 1 : len;
      // a huge length is never streamed to the end
      if (n > 4096) n = 64;
      for (int k = 0; k < n; k++) begin
         file_q.push_back(bgd_pkg::byte_type'($urandom_range(255)));
      end
      if (n >= bgd_pkg::HDR_LEN) begin
         put_le(0, hd.sig, 2);
         put_le(2, hd.size, 4);
         put_le(10, hd.offset, 4);
         put_le(14, hd.info, 4);
         put_le(18, hd.wid, 4);
         put_le(22, hd.hgt, 4);
         put_le(28, hd.bpp, 2);
         put_le(30, hd.comp, 4);
      end
   endfunction

   task automatic send_byte(bgd_pkg::byte_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      n_bytes++;
   endtask

   task automatic wait_idle();
      while (n_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // set the length, stream file_q, then let the block drain
   task automatic play_file(bit [31:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len[30:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      foreach (file_q[k]) send_byte(file_q[k]);
      req_if.valid <= 1'b0;
      n_files++;
      wait_idle();
   endtask

   task automatic run_file(bit [31:0] len, bmp_head_type hd);
      build_file(len, hd);
      play_file(len);
   endtask

   task automatic run_clean(bit [31:0] len, bit [31:0] w, bit [31:0] h);
      run_file(len, clean_head(len, w, h));
   endtask

   // mostly well-formed files with random size and content, the rest broken
   task automatic random_file();
      bmp_head_type hd;
      bit [31:0] w;
      bit [31:0] h;
      bit [31:0] need;
      bit [31:0] len;
      int        pick;
      int        fault_kind;
      pick = $urandom_range(99);
      w    = $urandom_range(0, 9);
      h    = $urandom_range(0, 4);
      fault_kind = $urandom_range(0, 8);
      if (pick < 10) begin
         // one dimension at the top of the range, cut short early
         if ($urandom_range(1)) w = bgd_pkg::MAX_DIMENSION - $urandom_range(1);
         else h = bgd_pkg::MAX_DIMENSION - $urandom_range(1);
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         len = bgd_pkg::HDR_LEN + $urandom_range(0, 40);
      end else begin
         need = pixel_bytes(w, h);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = bgd_pkg::HDR_LEN + need;
            5, 6:          len = bgd_pkg::HDR_LEN + need + $urandom_range(1, 5);
            default: begin
               if (need == 0) len = bgd_pkg::HDR_LEN + $urandom_range(0, 3);
               else len = bgd_pkg::HDR_LEN + need - $urandom_range(1, (need < 8) ? need : 8);
            end
         endcase
      end
      hd = clean_head(len, w, h);
      if (pick >= 70) begin
         case (fault_kind)
            0: len = $urandom_range(0, bgd_pkg::HDR_LEN - 1);
            1: hd.sig = hd.sig ^ (16'h1 << $urandom_range(15));
            2: hd.size = hd.size + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
            3: hd.info = $urandom_range(1) ? 32'd12 : $urandom;
            4: begin
               if ($urandom_range(1)) begin
                  hd.wid = bgd_pkg::MAX_DIMENSION + 1 + $urandom_range(0, 6382);
               end else begin
                  hd.hgt = 32'hFFFF_FFFF - $urandom_range(0, 15);
               end
            end
            5: hd.bpp = hd.bpp ^ (16'h1 << $urandom_range(15));
            6: hd.comp = $urandom_range(1, 3);
            7: hd.offset = bgd_pkg::HDR_LEN ^ (32'h1 << $urandom_range(31));
            default: ;
         endcase
      end
      build_file(len, hd);
      // garbage header
      if (pick >= 70 && fault_kind == 8) begin
         for (int k = 0; k < bgd_pkg::HDR_LEN; k++) begin
            file_q[k] = bgd_pkg::byte_type'($urandom_range(255));
         end
      end
      play_file(len);
   endtask

   // stimulus and verdict
   initial begin
      int unsigned mark;
      bit [31:0]   len2x2;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      reset            = 1'b1;
      idle_pct         = 0;
      stall_pct        = 0;
      rsp_hold         = 1'b0;
      n_files          = 0;
      n_bytes          = 0;
      len2x2           = bgd_pkg::HDR_LEN + pixel_bytes(2, 2);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // too short for a header
      run_clean(0, 0, 0);

      // random files under four idling profiles
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         if (p == 0) begin
            // hold results off long enough to back the block up
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (300) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
            // 2x2 image, first pixels black and white
            build_file(len2x2, clean_head(len2x2, 2, 2));
            for (int k = 54; k < 57; k++) file_q[k] = 8'h00;
            for (int k = 57; k < 60; k++) file_q[k] = 8'hFF;
            play_file(len2x2);
         end
         mark = n_bytes;
         while (n_bytes - mark < PHASE_BYTES) random_file();
      end

      // length just under the largest: one pixel, then trailing data that is never sent in full
      idle_pct  = 0;
      stall_pct = 0;
      run_clean(32'h7FFF_FFFE, 1, 1);

      $display("covered %0d files, %0d bytes, %0d gray pixels, %0d file ends",
               n_files, n_bytes, n_pixels, n_ends);
      $display("completion codes seen, one bit per code: %b", codes_seen[10:0]);
      if (n_pending != 0) $display("%0d predicted results never arrived", n_pending);
      if (n_fail == 0 && n_pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/bgd_pkg.sv
rtl/bgd_byte_if.sv
rtl/bgd_pix_if.sv
rtl/bmp24_to_gray_decoder_top.sv
test/bgd_gray_scoreboard.sv
test/tb_top.sv
